// ===== rtl/swm_pkg.sv =====
// Shared constants, types and helpers of the sliding window maximum block.
`default_nettype none

package swm_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int WINDOW_WIDTH = 7;
   localparam int TAP_WIDTH    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int COUNT_WIDTH  = $clog2(MAX_WINDOW + 2);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [WINDOW_WIDTH-1:0]        window_type;
   typedef logic [COUNT_WIDTH-1:0]         count_type;
   typedef logic [TAP_WIDTH-1:0]           tap_type;

   typedef struct packed {
      logic shift;
      logic restart;
   } cell_ctrl_type;

   function automatic count_type effective_window(input window_type size);
      count_type w;
      begin
         w = COUNT_WIDTH'(size);
         if (size == '0) begin
            w = COUNT_WIDTH'(1);
         end else if (int'(size) > MAX_WINDOW) begin
            w = COUNT_WIDTH'(MAX_WINDOW);
         end
         return w;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// One cell of the chain: holds the maximum over the samples from age zero up to its own age.
`default_nettype none

module swm_cell (
   input  wire                   clock,
   input  swm_pkg::cell_ctrl_type ctrl,
   input  swm_pkg::sample_type   sample,
   input  swm_pkg::sample_type   prev,
   output swm_pkg::sample_type   value_in,
   output swm_pkg::sample_type   value
);

   swm_pkg::sample_type value_ff;

   // The neighbor's maximum ages by one sample; the new sample joins it, or stands alone on restart.
   always_comb begin
      if (ctrl.restart || (prev <= sample)) begin
         value_in = sample;
      end else begin
         value_in = prev;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_maximum.sv =====
// Top level of the sliding window maximum: cell chain, sample counter and result register.
// A result is in the output register in the cycle after its input transfer.
// Throughput: one sample per cycle unless stalled; each cell updates from its neighbor per sample.
// The input stalls only while a result waits in the output register and is stalled.
// Reset clears the sample count and the output valid and sets the window size to one.
// Cell contents are not reset; a new sequence or the sample count keeps them out of results.
`default_nettype none

module sliding_window_maximum (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire signed [swm_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  wire                                    req_start_new,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic signed [swm_pkg::SAMPLE_WIDTH-1:0] rsp_window_max,
   input  wire                                    csr_wr_en,
   input  wire [swm_pkg::WINDOW_WIDTH-1:0]        csr_window_size
);

   swm_pkg::window_type    window_size_ff;
   swm_pkg::count_type     seen_ff;
   swm_pkg::count_type     seen_in;
   swm_pkg::count_type     seen_base;
   swm_pkg::count_type     seen_inc;
   swm_pkg::count_type     w_eff;
   swm_pkg::tap_type       tap_index;
   swm_pkg::cell_ctrl_type cell_ctrl;
   swm_pkg::sample_type    cell_prev [swm_pkg::MAX_WINDOW];
   swm_pkg::sample_type    cell_next [swm_pkg::MAX_WINDOW];
   swm_pkg::sample_type    cell_value [swm_pkg::MAX_WINDOW];
   swm_pkg::sample_type    rsp_window_max_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   req_accept;
   logic                   result_ready;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign w_eff     = swm_pkg::effective_window(window_size_ff);
   assign tap_index = swm_pkg::TAP_WIDTH'(w_eff - 1'b1);

   assign cell_ctrl.shift   = req_accept;
   assign cell_ctrl.restart = req_start_new;

   genvar k;
   generate
      for (k = 0; k < swm_pkg::MAX_WINDOW; k++) begin : g_cell
         if (k == 0) begin : g_head
            assign cell_prev[k] = req_sample;
         end else begin : g_link
            assign cell_prev[k] = cell_value[k-1];
         end
         swm_cell u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl),
            .sample   (req_sample),
            .prev     (cell_prev[k]),
            .value_in (cell_next[k]),
            .value    (cell_value[k])
         );
      end
   endgenerate

   always_comb begin
      seen_base = req_start_new ? '0 : seen_ff;
      seen_inc  = seen_base + 1'b1;
      if (seen_inc > w_eff) begin
         seen_in = w_eff;
      end else begin
         seen_in = seen_inc;
      end
      result_ready = (seen_in == w_eff);
      if (req_accept) begin
         rsp_valid_in = result_ready;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swm_pkg::WINDOW_WIDTH'(1);
         seen_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_size_ff <= csr_window_size;
         end
         if (req_accept) begin
            seen_ff <= seen_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && result_ready) begin
         rsp_window_max_ff <= cell_next[tap_index];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_window_max_ff;

`ifndef SYNTHESIS
   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> seen_ff <= $past(w_eff))
      else $error("Sample count exceeds the window size.");

   a_restart_no_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_start_new && (w_eff != swm_pkg::COUNT_WIDTH'(1)) |=> !rsp_valid_ff)
      else $error("A restarted sequence produced a result too early.");

   a_unit_window: assert property (@(posedge clock) disable iff (reset)
      req_accept && (w_eff == swm_pkg::COUNT_WIDTH'(1))
      |=> rsp_valid_ff && (rsp_window_max_ff == $past(req_sample)))
      else $error("A window of one did not return the sample itself.");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("Input stalled without a held result.");
`endif

endmodule

`default_nettype wire

// ===== tb/sliding_window_maximum_tb.sv =====
// Self-checking testbench of the sliding window maximum, with directed and random sample streams.
`timescale 1ns / 100ps

module sliding_window_maximum_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 3;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 200;

   typedef struct packed {
      logic                write_size;
      swm_pkg::window_type size;
      swm_pkg::sample_type sample;
      logic                start;
      logic                typed;
      swm_pkg::sample_type typed_max;
   } plan_row_type;

   localparam swm_pkg::sample_type TOP    = 32'sh7FFFFFFF;
   localparam swm_pkg::sample_type BOTTOM = 32'sh80000000;

   plan_row_type plan [22] = '{
      '{1'b0, 7'd0,   32'sd0,  1'b1, 1'b1, 32'sd0},
      '{1'b0, 7'd0,   TOP,     1'b0, 1'b1, TOP},
      '{1'b0, 7'd0,   BOTTOM,  1'b0, 1'b1, BOTTOM},
      '{1'b0, 7'd0,   -32'sd1, 1'b0, 1'b1, -32'sd1},
      '{1'b0, 7'd0,   32'sd1,  1'b0, 1'b1, 32'sd1},
      '{1'b1, 7'd3,   32'sd5,  1'b1, 1'b0, 32'sd0},
      '{1'b0, 7'd0,   32'sd5,  1'b0, 1'b0, 32'sd0},
      '{1'b0, 7'd0,   32'sd5,  1'b0, 1'b0, 32'sd0},
      '{1'b0, 7'd0,   -32'sd7, 1'b0, 1'b0, 32'sd0},
      '{1'b0, 7'd0,   32'sd9,  1'b0, 1'b0, 32'sd0},
      '{1'b0, 7'd0,   32'sd9,  1'b0, 1'b0, 32'sd0},
      '{1'b0, 7'd0,   BOTTOM,  1'b0, 1'b0, 32'sd0},
      '{1'b0, 7'd0,   BOTTOM,  1'b0, 1'b0, 32'sd0},
      '{1'b1, 7'd0,   BOTTOM,  1'b0, 1'b1, BOTTOM},
      '{1'b0, 7'd0,   32'sd42, 1'b0, 1'b1, 32'sd42},
      '{1'b1, 7'd127, 32'sd3,  1'b1, 1'b0, 32'sd0},
      '{1'b0, 7'd0,   32'sd2,  1'b0, 1'b0, 32'sd0},
      '{1'b1, 7'd2,   32'sd1,  1'b0, 1'b0, 32'sd0},
      '{1'b0, 7'd0,   TOP,     1'b1, 1'b0, 32'sd0},
      '{1'b0, 7'd0,   32'sd0,  1'b0, 1'b0, 32'sd0},
      '{1'b1, 7'd65,  -32'sd5, 1'b1, 1'b0, 32'sd0},
      '{1'b1, 7'd1,   -32'sd6, 1'b0, 1'b1, -32'sd6}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   swm_pkg::sample_type req_sample = '0;
   logic                req_start_new = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   swm_pkg::sample_type rsp_window_max;
   logic                csr_wr_en = 1'b0;
   swm_pkg::window_type csr_window_size = '0;

   swm_pkg::sample_type expected_max [$];
   swm_pkg::sample_type cand_value [$];
   int                  cand_age [$];
   int                  seen_count = 0;
   swm_pkg::window_type window_reg = 7'd1;

   bit idle_on = 1'b1;
   int stall_left = 0;
   int cycle_count = 0;
   int error_count = 0;
   int items_sent = 0;
   int maxima_checked = 0;

   sliding_window_maximum dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_start_new   (req_start_new),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_window_max  (rsp_window_max),
      .csr_wr_en       (csr_wr_en),
      .csr_window_size (csr_window_size)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int idle_draw();
      return idle_on ? int'($urandom_range(0, 4)) : 0;
   endfunction

   task automatic update_window_max(input swm_pkg::sample_type value, input bit first,
                                    output bit produced, output swm_pkg::sample_type result);
      int span;
      span = (window_reg == '0) ? 1 :
             (int'(window_reg) > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW :
             int'(window_reg);
      if (first) begin
         cand_value.delete();
         cand_age.delete();
         seen_count = 0;
      end
      foreach (cand_age[i]) cand_age[i]++;
      while (cand_age.size() != 0 && cand_age[0] >= span) begin
         void'(cand_age.pop_front());
         void'(cand_value.pop_front());
      end
      while (cand_value.size() != 0 && cand_value[$] <= value) begin
         void'(cand_age.pop_back());
         void'(cand_value.pop_back());
      end
      if (cand_value.size() < swm_pkg::MAX_WINDOW) begin
         cand_value.push_back(value);
         cand_age.push_back(0);
      end
      seen_count = (seen_count + 1 > span) ? span : seen_count + 1;
      produced = (seen_count >= span);
      result = cand_value[0];
   endtask

   task automatic send_sample(input swm_pkg::sample_type value, input bit first,
                              input bit typed, input swm_pkg::sample_type typed_max);
      int                  gap;
      bit                  produced;
      swm_pkg::sample_type predicted;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      req_start_new <= first;
      do @(posedge clock); while (req_stall);
      update_window_max(value, first, produced, predicted);
      if (typed) begin
         expected_max.push_back(typed_max);
      end else if (produced) begin
         expected_max.push_back(predicted);
      end
      items_sent++;
   endtask

   // Hold off the sender until every outstanding window maximum has arrived.
   task automatic drain_pending();
      req_valid <= 1'b0;
      while (expected_max.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_window(input swm_pkg::window_type size);
      drain_pending();
      csr_wr_en <= 1'b1;
      csr_window_size <= size;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      window_reg = size;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d window maxima outstanding", $time,
                  expected_max.size());
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_max.size() == 0) begin
               $display("%0t: window max expected none, got %0d", $time, rsp_window_max);
               error_count++;
            end else begin
               if (rsp_window_max !== expected_max[0]) begin
                  $display("%0t: window max expected %0d, got %0d", $time,
                           expected_max[0], rsp_window_max);
                  error_count++;
               end
               void'(expected_max.pop_front());
            end
            maxima_checked++;
            stall_left = idle_draw();
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   initial begin
      swm_pkg::window_type size;
      swm_pkg::sample_type value;
      bit                  first;
      int                  pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].write_size) program_window(plan[r].size);
         send_sample(plan[r].sample, plan[r].start, plan[r].typed, plan[r].typed_max);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: size = 7'd2;
            1: size = 7'd64;
            2: size = 7'd0;
            3: size = 7'd5;
            4: size = 7'd127;
            5: size = 7'd1;
            6: size = 7'd65;
            7: size = 7'd33;
            default: size = swm_pkg::window_type'($urandom_range(0, 127));
         endcase
         program_window(size);
         idle_on = (phase % 3 != 2);
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            if (item == PHASE_ITEMS / 2) drain_pending();
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
               value = $urandom;
            end else if (pick < 17) begin
               value = int'($urandom_range(0, 6)) - 3;
            end else begin
               case ($urandom_range(0, 3))
                  0: value = TOP;
                  1: value = TOP - 1;
                  2: value = BOTTOM;
                  default: value = BOTTOM + 1;
               endcase
            end
            // Odd phases carry the previous sequence across the size change.
            first = (item == 0 && phase % 2 == 0) || ($urandom_range(0, 299) == 0);
            send_sample(value, first, 1'b0, '0);
         end
      end
      idle_on = 1'b1;
      drain_pending();

      $display("%0d samples sent and %0d window maxima checked, over window sizes", items_sent,
               maxima_checked);
      $display("from zero to 127, with size changes inside running sequences");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
